// File: rtl/edfs_pkg.sv
// ----------------------------------------------------------------------------
// edfs_pkg
// shared types, codes and constants of the earliest-deadline-first selector
// ----------------------------------------------------------------------------
`default_nettype none

package edfs_pkg;

    // default number of task slots
    localparam int TASK_SLOTS_DEF = 16;

    // field widths
    localparam int MODE_W     = 3;
    localparam int TSLOT_W    = 4;
    localparam int DEADLINE_W = 64;
    localparam int STAMP_W    = 32;

    // event codes
    localparam logic [MODE_W-1:0] MODE_SCHEDULE     = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CANCEL       = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COMPLETE     = 3'd2;
    localparam logic [MODE_W-1:0] MODE_PICK         = 3'd3;
    localparam logic [MODE_W-1:0] MODE_SET_DEADLINE = 3'd4;

    // special deadlines
    localparam logic [DEADLINE_W-1:0] DEADLINE_NOW  = '0;
    localparam logic [DEADLINE_W-1:0] DEADLINE_IDLE = '1;

    // schedule refusal code
    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_BUSY = 1'b1;

    // per-slot status
    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_QUEUED  = 2'd1,
        ST_RUNNING = 2'd2
    } slot_st_t;

    // write enables of the slot store
    typedef struct packed {
        logic dl_we;
        logic stamp_we;
    } mem_wr_t;

    // control of the shared compare unit
    typedef struct packed {
        logic clear;
        logic step;
        logic active;
    } cmp_ctl_t;

    // slot takes part in a pick
    function automatic logic slot_active(slot_st_t s);
        return (s == ST_QUEUED) || (s == ST_RUNNING);
    endfunction

endpackage

`default_nettype wire

// File: rtl/edfs_slot_mem.sv
// ----------------------------------------------------------------------------
// edfs_slot_mem
// deadline and arrival stamp store, one write port and one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module edfs_slot_mem #(
    parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF,
    parameter int SLOT_W     = $clog2(TASK_SLOTS)
) (
    input  wire                                clk,
    input  edfs_pkg::mem_wr_t                  wr,
    input  wire  [SLOT_W-1:0]                  wr_addr,
    input  wire  [edfs_pkg::DEADLINE_W-1:0]    wr_deadline,
    input  wire  [edfs_pkg::STAMP_W-1:0]       wr_stamp,
    input  wire  [SLOT_W-1:0]                  rd_addr,
    output logic [edfs_pkg::DEADLINE_W-1:0]    rd_deadline,
    output logic [edfs_pkg::STAMP_W-1:0]       rd_stamp
);

    logic [edfs_pkg::DEADLINE_W-1:0] dl_mem    [TASK_SLOTS];
    logic [edfs_pkg::STAMP_W-1:0]    stamp_mem [TASK_SLOTS];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr.dl_we)
        begin
            dl_mem[wr_addr] <= wr_deadline;
        end
        if (wr.stamp_we)
        begin
            stamp_mem[wr_addr] <= wr_stamp;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rd_deadline <= dl_mem[rd_addr];
        rd_stamp    <= stamp_mem[rd_addr];
    end

endmodule

`default_nettype wire

// File: rtl/edfs_cmp_unit.sv
// ----------------------------------------------------------------------------
// edfs_cmp_unit
// shared compare step: folds one candidate slot per cycle into the running best
// ----------------------------------------------------------------------------
`default_nettype none

module edfs_cmp_unit #(
    parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF,
    parameter int SLOT_W     = $clog2(TASK_SLOTS)
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  edfs_pkg::cmp_ctl_t                 ctl,
    input  wire  [SLOT_W-1:0]                  cand_slot,
    input  wire  [edfs_pkg::DEADLINE_W-1:0]    cand_deadline,
    input  wire  [edfs_pkg::STAMP_W-1:0]       cand_stamp,
    input  wire  [edfs_pkg::STAMP_W-1:0]       arrival_count,
    output logic                               found,
    output logic [SLOT_W-1:0]                  best_slot
);

    logic                             found_reg, found_next;
    logic                             found_now_reg, found_now_next;
    logic [SLOT_W-1:0]                best_reg, best_next;
    logic [edfs_pkg::DEADLINE_W-1:0]  best_dl_reg, best_dl_next;
    logic [edfs_pkg::STAMP_W-1:0]     best_age_reg, best_age_next;
    logic [edfs_pkg::STAMP_W-1:0]     cand_age;
    logic                             is_now;

    // age of the candidate, wraps with the counter
    assign cand_age = arrival_count - cand_stamp;
    assign is_now   = (cand_deadline == edfs_pkg::DEADLINE_NOW);

    // one compare step
    always_comb
    begin
        found_next     = found_reg;
        found_now_next = found_now_reg;
        best_next      = best_reg;
        best_dl_next   = best_dl_reg;
        best_age_next  = best_age_reg;
        if (ctl.clear)
        begin
            found_next     = 1'b0;
            found_now_next = 1'b0;
            best_next      = '0;
            best_dl_next   = edfs_pkg::DEADLINE_IDLE;
            best_age_next  = '0;
        end
        else if (ctl.step && ctl.active)
        begin
            if (is_now)
            begin
                // oldest zero-deadline slot beats everything
                if (!found_now_reg || (cand_age > best_age_reg))
                begin
                    found_now_next = 1'b1;
                    best_next      = cand_slot;
                    best_age_next  = cand_age;
                end
                found_next = 1'b1;
            end
            else if (!found_now_reg)
            begin
                // smallest deadline, later arrival on a tie
                if (!found_reg || (cand_deadline < best_dl_reg) ||
                    ((cand_deadline == best_dl_reg) && (cand_age < best_age_reg)))
                begin
                    best_next     = cand_slot;
                    best_dl_next  = cand_deadline;
                    best_age_next = cand_age;
                    found_next    = 1'b1;
                end
            end
        end
    end

    // control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            found_now_reg <= 1'b0;
        end
        else
        begin
            found_reg     <= found_next;
            found_now_reg <= found_now_next;
        end
    end

    // best candidate payload
    always_ff @(posedge clk)
    begin
        best_reg     <= best_next;
        best_dl_reg  <= best_dl_next;
        best_age_reg <= best_age_next;
    end

    assign found     = found_reg;
    assign best_slot = best_reg;

endmodule

`default_nettype wire

// File: rtl/edf_task_selector_core.sv
// ----------------------------------------------------------------------------
// edf_task_selector_core
// earliest-deadline-first task selector with a slot table and serial pick scan
// ----------------------------------------------------------------------------
// Usage:
//   Events enter on the input channel (in_valid/in_ready) as mode, task_slot
//   and deadline; every event gives exactly one result on the output channel
//   (out_valid/out_ready) as status, picked_valid and picked_slot.
//   Schedule, cancel, complete and set deadline finish in the accept cycle;
//   their result is shown on the next cycle from the output register.
//   Pick walks the slot table through one shared compare unit, one slot per
//   cycle from the registered read port of the deadline/stamp store, then
//   passes the drain and done states; done waits for a free output register.
//   in_ready is high only while no pick is being scanned and the output
//   register is empty or being taken this cycle; a stalled receiver thus
//   holds the block after one pending result.
//   Reset sets every slot idle, clears the arrival counter and empties the
//   output register; deadline and stamp storage is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_task_selector_core #(
    parameter int TASK_SLOTS = edfs_pkg::TASK_SLOTS_DEF
) (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                in_valid,
    output logic                               in_ready,
    input  wire  [edfs_pkg::MODE_W-1:0]        mode,
    input  wire  [edfs_pkg::TSLOT_W-1:0]       task_slot,
    input  wire  [edfs_pkg::DEADLINE_W-1:0]    deadline,
    output logic                               out_valid,
    input  wire                                out_ready,
    output logic                               status,
    output logic                               picked_valid,
    output logic [edfs_pkg::TSLOT_W-1:0]       picked_slot
);

    localparam int SLOT_W = $clog2(TASK_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TASK_SLOTS - 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } state_t;

    state_t                          state_reg, state_next;
    edfs_pkg::slot_st_t              slot_st_reg [TASK_SLOTS];
    edfs_pkg::slot_st_t              slot_st_next [TASK_SLOTS];
    logic [edfs_pkg::STAMP_W-1:0]    arr_cnt_reg, arr_cnt_next;
    logic [SLOT_W-1:0]               scan_idx_reg, scan_idx_next;
    logic                            pend_reg, pend_next;
    logic                            act_reg, act_next;
    logic [SLOT_W-1:0]               cand_reg, cand_next;
    logic                            out_valid_reg, out_valid_next;
    logic                            status_reg, status_next;
    logic                            pvalid_reg, pvalid_next;
    logic [edfs_pkg::TSLOT_W-1:0]    pslot_reg, pslot_next;

    logic                            accept;
    logic                            out_free;
    logic                            in_range;
    logic [SLOT_W-1:0]               wr_addr;
    edfs_pkg::mem_wr_t               mem_wr;
    edfs_pkg::cmp_ctl_t              cmp_ctl;
    logic [edfs_pkg::DEADLINE_W-1:0] rd_deadline;
    logic [edfs_pkg::STAMP_W-1:0]    rd_stamp;
    logic                            cmp_found;
    logic [SLOT_W-1:0]               cmp_best;

    // handshake
    assign out_free = !out_valid_reg || out_ready;
    assign in_ready = (state_reg == S_IDLE) && out_free;
    assign accept   = in_valid && in_ready;
    assign in_range = (32'(task_slot) < 32'(TASK_SLOTS));
    assign wr_addr  = SLOT_W'(task_slot);

    // deadline and stamp store
    edfs_slot_mem #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_mem (
        .clk         (clk),
        .wr          (mem_wr),
        .wr_addr     (wr_addr),
        .wr_deadline (deadline),
        .wr_stamp    (arr_cnt_reg),
        .rd_addr     (scan_idx_reg),
        .rd_deadline (rd_deadline),
        .rd_stamp    (rd_stamp)
    );

    // shared compare unit
    edfs_cmp_unit #(
        .TASK_SLOTS (TASK_SLOTS),
        .SLOT_W     (SLOT_W)
    ) u_cmp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (cmp_ctl),
        .cand_slot     (cand_reg),
        .cand_deadline (rd_deadline),
        .cand_stamp    (rd_stamp),
        .arrival_count (arr_cnt_reg),
        .found         (cmp_found),
        .best_slot     (cmp_best)
    );

    // sequencer and event handling
    always_comb
    begin
        state_next     = state_reg;
        slot_st_next   = slot_st_reg;
        arr_cnt_next   = arr_cnt_reg;
        scan_idx_next  = scan_idx_reg;
        pend_next      = 1'b0;
        act_next       = act_reg;
        cand_next      = cand_reg;
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        pvalid_next    = pvalid_reg;
        pslot_next     = pslot_reg;
        mem_wr         = '0;
        cmp_ctl.clear  = 1'b0;
        cmp_ctl.step   = pend_reg;
        cmp_ctl.active = act_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode == edfs_pkg::MODE_PICK)
                    begin
                        state_next    = S_SCAN;
                        scan_idx_next = '0;
                        cmp_ctl.clear = 1'b1;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        status_next    = edfs_pkg::STATUS_OK;
                        pvalid_next    = 1'b0;
                        pslot_next     = '0;
                        if (in_range)
                        begin
                            unique case (mode)
                                edfs_pkg::MODE_SCHEDULE:
                                begin
                                    if (edfs_pkg::slot_active(slot_st_reg[wr_addr]))
                                    begin
                                        status_next = edfs_pkg::STATUS_BUSY;
                                    end
                                    else
                                    begin
                                        mem_wr.dl_we          = 1'b1;
                                        mem_wr.stamp_we       = 1'b1;
                                        arr_cnt_next          = arr_cnt_reg + 1'b1;
                                        slot_st_next[wr_addr] = edfs_pkg::ST_QUEUED;
                                    end
                                end
                                edfs_pkg::MODE_CANCEL:
                                begin
                                    if (slot_st_reg[wr_addr] == edfs_pkg::ST_QUEUED)
                                    begin
                                        slot_st_next[wr_addr] = edfs_pkg::ST_IDLE;
                                    end
                                end
                                edfs_pkg::MODE_COMPLETE:
                                begin
                                    slot_st_next[wr_addr] = edfs_pkg::ST_IDLE;
                                end
                                edfs_pkg::MODE_SET_DEADLINE:
                                begin
                                    mem_wr.dl_we = 1'b1;
                                end
                                default:
                                begin
                                end
                            endcase
                        end
                    end
                end
            end
            S_SCAN:
            begin
                // issue one slot read, compare it next cycle
                pend_next = 1'b1;
                act_next  = edfs_pkg::slot_active(slot_st_reg[scan_idx_reg]);
                cand_next = scan_idx_reg;
                if (scan_idx_reg == LAST_SLOT)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_idx_next = scan_idx_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                // last compare step runs here
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    status_next    = edfs_pkg::STATUS_OK;
                    pvalid_next    = cmp_found;
                    pslot_next     = cmp_found ? edfs_pkg::TSLOT_W'(cmp_best) : '0;
                    if (cmp_found)
                    begin
                        slot_st_next[cmp_best] = edfs_pkg::ST_RUNNING;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            arr_cnt_reg   <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                slot_st_reg[i] <= edfs_pkg::ST_IDLE;
            end
        end
        else
        begin
            state_reg     <= state_next;
            arr_cnt_reg   <= arr_cnt_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            slot_st_reg   <= slot_st_next;
        end
    end

    // scan and result payload
    always_ff @(posedge clk)
    begin
        scan_idx_reg <= scan_idx_next;
        act_reg      <= act_next;
        cand_reg     <= cand_next;
        status_reg   <= status_next;
        pvalid_reg   <= pvalid_next;
        pslot_reg    <= pslot_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign picked_valid = pvalid_reg;
    assign picked_slot  = pslot_reg;

endmodule

`default_nettype wire

// File: tb/sv/edf_task_selector_core_test.sv
// ----------------------------------------------------------------------------
// edf_task_selector_core_test
// self-checking bench for the earliest-deadline-first task selector
// ----------------------------------------------------------------------------
// Events go in one at a time over the valid/ready input channel. On each
// input transfer a local slot table predicts the single result, which waits
// in a queue. Every output transfer is compared field by field with the
// oldest prediction. The run covers these parts in turn:
//   - hand-picked event sequences
//   - a long receiver stall that fills the block
//   - sender pauses until the block is drained
//   - biased random traffic
// Both sides insert random idle bursts, except in the final stretch.
// ----------------------------------------------------------------------------
`default_nettype none

module edf_task_selector_core_test;

    timeunit 1ns;
    timeprecision 1ps;

    import edfs_pkg::*;

    localparam int NSLOTS = TASK_SLOTS_DEF;

    // modes with no defined event
    localparam logic [MODE_W-1:0] MODE_RSVD_FIRST = 3'd5;
    localparam int                RSVD_MODES      = 3;

    localparam int LONG_HOLD     = 150;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = NSLOTS + 16;
    localparam int RANDOM_ITEMS  = 1160;
    localparam int QUIET_ITEMS   = 200;

    // one result of the block
    typedef struct packed {
        logic               status;
        logic               picked_valid;
        logic [TSLOT_W-1:0] picked_slot;
    } sel_result_t;

    logic                  clk          = 1'b0;
    logic                  rst_n        = 1'b0;
    logic                  in_valid     = 1'b0;
    logic                  in_ready;
    logic [MODE_W-1:0]     mode         = MODE_SCHEDULE;
    logic [TSLOT_W-1:0]    task_slot    = '0;
    logic [DEADLINE_W-1:0] deadline     = '0;
    logic                  out_valid;
    logic                  out_ready    = 1'b0;
    logic                  status;
    logic                  picked_valid;
    logic [TSLOT_W-1:0]    picked_slot;

    // local copy of the slot table
    slot_st_t              slot_table    [NSLOTS];
    logic [DEADLINE_W-1:0] slot_due      [NSLOTS];
    logic [STAMP_W-1:0]    slot_stamp    [NSLOTS];
    logic [STAMP_W-1:0]    arrival_count = '0;

    sel_result_t pending_results [$];
    int          mismatches    = 0;
    int          quiet_cycles  = 0;
    int          hold_requests = 0;
    int          holds_served  = 0;
    bit          bursts_on     = 1'b1;

    edf_task_selector_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .mode         (mode),
        .task_slot    (task_slot),
        .deadline     (deadline),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .picked_valid (picked_valid),
        .picked_slot  (picked_slot)
    );

    always #5 clk = ~clk;

    function automatic bit slot_in_use(input slot_st_t st);
        return (st == ST_QUEUED) || (st == ST_RUNNING);
    endfunction

    // apply one event to the local table and return its result
    function automatic sel_result_t sched_step(input logic [MODE_W-1:0]     m,
                                               input logic [TSLOT_W-1:0]    s,
                                               input logic [DEADLINE_W-1:0] dl);
        sel_result_t           r;
        bit                    found;
        bit                    found_now;
        logic [TSLOT_W-1:0]    best;
        logic [DEADLINE_W-1:0] best_due;
        logic [STAMP_W-1:0]    best_age;
        logic [STAMP_W-1:0]    age;
        r         = '0;
        found     = 1'b0;
        found_now = 1'b0;
        best      = '0;
        best_due  = DEADLINE_IDLE;
        best_age  = '0;
        case (m)
            MODE_PICK:
            begin
                for (int i = 0; i < NSLOTS; i++)
                begin
                    if (slot_in_use(slot_table[i]))
                    begin
                        age = arrival_count - slot_stamp[i];
                        if (slot_due[i] == DEADLINE_NOW)
                        begin
                            // oldest zero deadline beats everything
                            if (!found_now || age > best_age)
                            begin
                                found_now = 1'b1;
                                best      = TSLOT_W'(i);
                                best_age  = age;
                            end
                            found = 1'b1;
                        end
                        else if (!found_now && (!found || slot_due[i] < best_due ||
                                 (slot_due[i] == best_due && age < best_age)))
                        begin
                            // smallest deadline, later arrival on a tie
                            best     = TSLOT_W'(i);
                            best_due = slot_due[i];
                            best_age = age;
                            found    = 1'b1;
                        end
                    end
                end
                if (found)
                begin
                    slot_table[best] = ST_RUNNING;
                    r.picked_valid   = 1'b1;
                    r.picked_slot    = best;
                end
            end
            MODE_SCHEDULE:
            begin
                if (slot_in_use(slot_table[s]))
                    r.status = STATUS_BUSY;
                else
                begin
                    slot_due[s]   = dl;
                    slot_stamp[s] = arrival_count;
                    arrival_count = arrival_count + 1;
                    slot_table[s] = ST_QUEUED;
                end
            end
            MODE_CANCEL:
            begin
                if (slot_table[s] == ST_QUEUED)
                    slot_table[s] = ST_IDLE;
            end
            MODE_COMPLETE:
                slot_table[s] = ST_IDLE;
            MODE_SET_DEADLINE:
                slot_due[s] = dl;
            default:
                r = '0;
        endcase
        return r;
    endfunction

    // offer one event, wait for its transfer, then record the prediction
    task automatic issue_event(input logic [MODE_W-1:0]     m,
                               input logic [TSLOT_W-1:0]    s,
                               input logic [DEADLINE_W-1:0] dl);
        if (bursts_on && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= m;
        task_slot <= s;
        deadline  <= dl;
        do
            @(negedge clk);
        while (!in_ready);
        @(posedge clk);
        pending_results.push_back(sched_step(m, s, dl));
    endtask

    // stop offering and wait until every result is back
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    function automatic logic [DEADLINE_W-1:0] rand_deadline();
        case ($urandom_range(0, 7))
            0:       return DEADLINE_NOW;
            1:       return DEADLINE_IDLE;
            2:       return DEADLINE_IDLE - 1;
            3, 4:    return DEADLINE_W'($urandom_range(1, 6));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // mostly a slot in the wanted state, sometimes any slot
    function automatic logic [TSLOT_W-1:0] slot_with(input slot_st_t want);
        int hits [$];
        for (int i = 0; i < NSLOTS; i++)
        begin
            if (slot_table[i] == want)
                hits.push_back(i);
        end
        if (hits.size() == 0 || $urandom_range(0, 3) == 0)
            return TSLOT_W'($urandom_range(0, NSLOTS - 1));
        return TSLOT_W'(hits[$urandom_range(0, hits.size() - 1)]);
    endfunction

    // one random event, biased toward sequences that reach busy tables
    task automatic random_event();
        logic [MODE_W-1:0]  m;
        logic [TSLOT_W-1:0] s;
        int                 r;
        r = $urandom_range(0, 99);
        if (r < 35)
        begin
            m = MODE_SCHEDULE;
            s = slot_with(ST_IDLE);
        end
        else if (r < 57)
        begin
            m = MODE_PICK;
            s = TSLOT_W'($urandom_range(0, NSLOTS - 1));
        end
        else if (r < 75)
        begin
            m = MODE_COMPLETE;
            s = slot_with(ST_RUNNING);
        end
        else if (r < 85)
        begin
            m = MODE_CANCEL;
            s = slot_with(ST_QUEUED);
        end
        else if (r < 95)
        begin
            m = MODE_SET_DEADLINE;
            s = slot_with($urandom_range(0, 1) ? ST_QUEUED : ST_RUNNING);
        end
        else
        begin
            m = MODE_RSVD_FIRST + MODE_W'($urandom_range(0, RSVD_MODES - 1));
            s = TSLOT_W'($urandom_range(0, NSLOTS - 1));
        end
        issue_event(m, s, rand_deadline());
    endtask

    // refusals, zero deadline order, ties, idle deadline, empty pick
    task automatic test_directed_cases();
        issue_event(MODE_SCHEDULE, 0, 100);
        issue_event(MODE_SCHEDULE, 0, 5);
        issue_event(MODE_PICK, 0, DEADLINE_NOW);
        issue_event(MODE_SCHEDULE, 0, DEADLINE_IDLE);
        issue_event(MODE_SCHEDULE, 1, DEADLINE_NOW);
        issue_event(MODE_SCHEDULE, 2, DEADLINE_NOW);
        issue_event(MODE_PICK, 0, DEADLINE_NOW);
        issue_event(MODE_SCHEDULE, 15, DEADLINE_IDLE);
        issue_event(MODE_SCHEDULE, 3, DEADLINE_IDLE - 1);
        issue_event(MODE_SCHEDULE, 4, 100);
        issue_event(MODE_COMPLETE, 1, DEADLINE_NOW);
        issue_event(MODE_COMPLETE, 2, DEADLINE_IDLE);
        issue_event(MODE_PICK, 15, DEADLINE_IDLE);
        issue_event(MODE_CANCEL, 3, DEADLINE_NOW);
        issue_event(MODE_CANCEL, 4, DEADLINE_NOW);
        issue_event(MODE_SET_DEADLINE, 15, DEADLINE_NOW);
        issue_event(MODE_PICK, 0, DEADLINE_NOW);
        for (int i = 0; i < RSVD_MODES; i++)
            issue_event(MODE_RSVD_FIRST + MODE_W'(i), 15, DEADLINE_IDLE);
        issue_event(MODE_COMPLETE, 0, DEADLINE_NOW);
        issue_event(MODE_COMPLETE, 4, DEADLINE_NOW);
        issue_event(MODE_COMPLETE, 15, DEADLINE_NOW);
        issue_event(MODE_PICK, 0, DEADLINE_NOW);
        issue_event(MODE_SET_DEADLINE, 7, DEADLINE_IDLE);
    endtask

    // receiver holds off while the sender keeps offering
    task automatic test_output_stall();
        hold_requests++;
        repeat (40)
            random_event();
    endtask

    // short groups with a full drain between them
    task automatic test_sender_pause();
        repeat (6)
        begin
            wait_drained();
            repeat (4)
                random_event();
        end
    endtask

    task automatic test_random_traffic();
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n == RANDOM_ITEMS - QUIET_ITEMS)
                bursts_on = 1'b0;
            random_event();
        end
    endtask

    // receiver side: random stall bursts and the long hold on request
    initial
    begin : receiver
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (bursts_on && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // compare each output transfer with the oldest prediction
    always @(negedge clk)
    begin : result_check
        sel_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: unexpected result status=%0b picked_valid=%0b picked_slot=%0d",
                         $time, status, picked_valid, picked_slot);
            end
            else
            begin
                want = pending_results.pop_front();
                if (status !== want.status)
                begin
                    mismatches++;
                    $display("%0t: status expected %0b got %0b",
                             $time, want.status, status);
                end
                if (picked_valid !== want.picked_valid)
                begin
                    mismatches++;
                    $display("%0t: picked_valid expected %0b got %0b",
                             $time, want.picked_valid, picked_valid);
                end
                if (picked_slot !== want.picked_slot)
                begin
                    mismatches++;
                    $display("%0t: picked_slot expected %0d got %0d",
                             $time, want.picked_slot, picked_slot);
                end
            end
        end
    end

    // end the run when no transfer happens for too long
    always @(negedge clk)
    begin : watchdog
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("FAIL edf_task_selector_core");
                $finish;
            end
        end
    end

    initial
    begin : main
        for (int i = 0; i < NSLOTS; i++)
        begin
            slot_table[i] = ST_IDLE;
            slot_due[i]   = '0;
            slot_stamp[i] = '0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed_cases();
        test_output_stall();
        test_sender_pause();
        test_random_traffic();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("PASS edf_task_selector_core");
        else
            $display("FAIL edf_task_selector_core");
        $finish;
    end

endmodule

`default_nettype wire

// File: edf_task_selector_core.f
rtl/edfs_pkg.sv
rtl/edfs_slot_mem.sv
rtl/edfs_cmp_unit.sv
rtl/edf_task_selector_core.sv
tb/sv/edf_task_selector_core_test.sv
